@@ hw/rtl/jpv_pkg.sv @@
package jpv_pkg;

	typedef enum logic [2:0] {
		PH_START      = 3'd0,
		PH_INT_ZERO   = 3'd1,
		PH_INT_DIGITS = 3'd2,
		PH_HASH       = 3'd3,
		PH_TOKEN      = 3'd4,
		PH_TILDE      = 3'd5,
		PH_CONT       = 3'd6,
		PH_FAIL       = 3'd7
	} phase_t;

	localparam int          CP_W         = 21;
	localparam int          APB_AW       = 3;
	localparam logic        REG_MODE     = 1'b0;

	localparam logic [7:0]  CH_SLASH     = 8'h2F;
	localparam logic [7:0]  CH_TILDE     = 8'h7E;
	localparam logic [7:0]  CH_HASH      = 8'h23;
	localparam logic [7:0]  CH_ZERO      = 8'h30;
	localparam logic [7:0]  CH_ONE       = 8'h31;
	localparam logic [7:0]  CH_NINE      = 8'h39;

	localparam logic [CP_W-1:0] CP_MIN2  = 21'h000080;
	localparam logic [CP_W-1:0] CP_MIN3  = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN4  = 21'h010000;
	localparam logic [CP_W-1:0] CP_SUR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SUR_HI = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;

endpackage

@@ hw/rtl/json_pointer_validator_top.sv @@
// JSON pointer syntax checker. Bytes of a string arrive one per stream
// transaction (tdata = byte, tuser = no-byte flag, tlast = end of string); a
// single-bit verdict leaves on the output stream for each string, in tdata bit 0.
// Register relative_mode at APB byte address 0 selects absolute (0) or relative (1)
// grammar. One byte is taken every clock cycle unless the input stage is held; a
// verdict enters the result register when its last byte leaves the input register.
// The parser state is updated between the input and result registers; a stalled
// output only holds the input stage once that stage holds a further end-of-string byte.
module json_pointer_validator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] text_byte
	input  logic                        s_axis_tuser,  // [0] no_byte
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [0] valid_res, [7:1] zero
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jpv_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import jpv_pkg::*;

	logic             mode_q;
	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             nob_s1;
	logic             last_s1;
	phase_t           phase_q;
	logic [1:0]       pend_q;
	logic [2:0]       width_q;
	logic [CP_W-1:0]  acc_q;
	logic             out_vld_q;
	logic             out_res_q;

	phase_t           phase_d;
	phase_t           phase_step;
	logic [1:0]       pend_d;
	logic [2:0]       width_d;
	logic [CP_W-1:0]  acc_d;
	logic             verdict;
	logic             advance;
	logic             digit;
	logic [CP_W-1:0]  acc_shift;
	logic [1:0]       pend_dec;
	logic             cp_ok;

	assign pready = 1'b1;
	assign prdata = {31'd0, (paddr[APB_AW-1] == REG_MODE) ? mode_q : 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_MODE) begin
			mode_q <= pwdata[0];
		end
	end

	assign advance       = vld_s1 && (!last_s1 || !out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			nob_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	assign digit     = byte_s1 >= CH_ZERO && byte_s1 <= CH_NINE;
	assign acc_shift = {acc_q[CP_W-7:0], byte_s1[5:0]};
	assign pend_dec  = pend_q - 2'd1;

	always_comb begin
		cp_ok = 1'b1;
		if (width_q == 3'd4 && acc_shift < CP_MIN4) cp_ok = 1'b0;
		if (width_q == 3'd3 && acc_shift < CP_MIN3) cp_ok = 1'b0;
		if (width_q == 3'd2 && acc_shift < CP_MIN2) cp_ok = 1'b0;
		if (acc_shift >= CP_SUR_LO && acc_shift <= CP_SUR_HI) cp_ok = 1'b0;
		if (acc_shift >= CP_LIMIT) cp_ok = 1'b0;
	end

	// next state
	always_comb begin
		phase_step = PH_FAIL;
		pend_d     = pend_q;
		width_d    = width_q;
		acc_d      = acc_q;
		case (phase_q)
			PH_START: begin
				if (mode_q) begin
					if (byte_s1 == CH_ZERO) phase_step = PH_INT_ZERO;
					else if (digit)         phase_step = PH_INT_DIGITS;
				end else if (byte_s1 == CH_SLASH) begin
					phase_step = PH_TOKEN;
				end
			end
			PH_INT_DIGITS: begin
				if (digit)                   phase_step = PH_INT_DIGITS;
				else if (byte_s1 == CH_HASH)  phase_step = PH_HASH;
				else if (byte_s1 == CH_SLASH) phase_step = PH_TOKEN;
			end
			PH_INT_ZERO: begin
				if (byte_s1 == CH_HASH)       phase_step = PH_HASH;
				else if (byte_s1 == CH_SLASH) phase_step = PH_TOKEN;
			end
			PH_TOKEN: begin
				if (byte_s1 == CH_TILDE) begin
					phase_step = PH_TILDE;
				end else if (!byte_s1[7]) begin
					phase_step = PH_TOKEN;
				end else if (byte_s1[7:5] == 3'b110) begin
					phase_step = PH_CONT;
					width_d    = 3'd2;
					pend_d     = 2'd1;
					acc_d      = {16'd0, byte_s1[4:0]};
				end else if (byte_s1[7:4] == 4'b1110) begin
					phase_step = PH_CONT;
					width_d    = 3'd3;
					pend_d     = 2'd2;
					acc_d      = {17'd0, byte_s1[3:0]};
				end else if (byte_s1[7:3] == 5'b11110) begin
					phase_step = PH_CONT;
					width_d    = 3'd4;
					pend_d     = 2'd3;
					acc_d      = {18'd0, byte_s1[2:0]};
				end
			end
			PH_TILDE: begin
				if (byte_s1 == CH_ZERO || byte_s1 == CH_ONE) phase_step = PH_TOKEN;
			end
			PH_CONT: begin
				if (byte_s1[7:6] == 2'b10) begin
					acc_d  = acc_shift;
					pend_d = pend_dec;
					if (pend_dec != 2'd0) phase_step = PH_CONT;
					else if (cp_ok)       phase_step = PH_TOKEN;
				end
			end
			default: phase_step = PH_FAIL;
		endcase
		if (nob_s1) begin
			phase_d = phase_q;
			pend_d  = pend_q;
			width_d = width_q;
			acc_d   = acc_q;
		end else begin
			phase_d = phase_step;
			if (phase_step == PH_FAIL) begin
				pend_d  = 2'd0;
				width_d = 3'd0;
				acc_d   = '0;
			end
		end
	end

	// verdict
	always_comb begin
		case (phase_d)
			PH_START:      verdict = !mode_q;
			PH_INT_ZERO,
			PH_INT_DIGITS,
			PH_HASH,
			PH_TOKEN:      verdict = 1'b1;
			default:       verdict = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pend_q  <= 2'd0;
			width_q <= 3'd0;
			acc_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_START;
				pend_q  <= 2'd0;
				width_q <= 3'd0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				pend_q  <= pend_d;
				width_q <= width_d;
				acc_q   <= acc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_res_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, out_res_q};

endmodule

@@ hw/rtl/jpv_checker.sv @@
module jpv_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [7:0]                  m_axis_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [jpv_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata
);
	import jpv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("verdict dropped or changed while stalled");

	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("verdict padding not zero");

	a_rd_pad: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:1] == 31'd0)
		else $error("register read padding not zero");

	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[APB_AW-1] == REG_MODE
		|=> paddr[APB_AW-1] != REG_MODE || prdata[0] == $past(pwdata[0]))
		else $error("mode register read-back mismatch");

endmodule

bind json_pointer_validator_top jpv_checker u_jpv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata)
);
